>>> design/ghts_pkg.sv
package ghts_pkg;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [31:0] GEN_RESET = 32'd3;

  localparam logic [2:0] HASH_LAST_STEP = 3'd5;

  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

  localparam logic [31:0] MIX_C0 = 32'h7ed55d16;
  localparam logic [31:0] MIX_C1 = 32'hc761c23c;
  localparam logic [31:0] MIX_C2 = 32'h165667b1;
  localparam logic [31:0] MIX_C3 = 32'hd3a2646c;
  localparam logic [31:0] MIX_C4 = 32'hfd7046c5;
  localparam logic [31:0] MIX_C5 = 32'hb55a4f09;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] expected_value;
  } in_item_t;

  typedef struct packed {
    logic is_different;
    logic is_stale;
  } out_item_t;

  // transaction handed from front to back through the queue
  typedef struct packed {
    logic        op;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] hash;
  } work_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] gen;
  } slot_t;

  // one step of the six-step integer mix
  function automatic logic [31:0] mix_step(input logic [2:0] n, input logic [31:0] a);
    logic [31:0] r;
    r = a;
    unique case (n)
      3'd0:    r = a + MIX_C0 + (a << 12);
      3'd1:    r = a ^ MIX_C1 ^ (a >> 19);
      3'd2:    r = a + MIX_C2 + (a << 5);
      3'd3:    r = (a + MIX_C3) ^ (a << 9);
      3'd4:    r = a + MIX_C4 + (a << 3);
      3'd5:    r = a ^ MIX_C5 ^ (a >> 16);
      default: r = a;
    endcase
    return r;
  endfunction

endpackage

>>> design/ghts_front.sv
module ghts_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  input  logic               in_valid,
  output logic               in_ready,
  input  ghts_pkg::in_item_t in_data,
  output logic               push_valid,
  input  logic               push_ready,
  output ghts_pkg::work_t    push_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t    state_r, state_nxt;
  logic [2:0]      step_r, step_nxt;
  ghts_pkg::work_t work_r, work_nxt;

  assign in_ready   = (state_r == F_IDLE) && !hold;
  assign push_valid = (state_r == F_PUSH);
  assign push_data  = work_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    work_nxt  = work_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          work_nxt.op    = in_data.op;
          work_nxt.key   = in_data.key;
          work_nxt.value = in_data.expected_value;
          work_nxt.hash  = in_data.key;
          step_nxt       = 3'd0;
          // clear transactions need no hash
          state_nxt      = (in_data.op == ghts_pkg::OP_CLEAR) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        work_nxt.hash = ghts_pkg::mix_step(step_r, work_r.hash);
        step_nxt      = step_r + 3'd1;
        if (step_r == ghts_pkg::HASH_LAST_STEP) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

endmodule

>>> design/ghts_queue.sv
module ghts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ghts_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ghts_pkg::work_t pop_data
);

  localparam int PW = ghts_pkg::QUEUE_PTR_W;

  ghts_pkg::work_t entry_r [ghts_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != (PW+1)'(ghts_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/ghts_back.sv
module ghts_back #(
  parameter int INDEX_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  output logic                init_busy,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  ghts_pkg::work_t     pop_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghts_pkg::out_item_t out_data
);

  localparam int SLOTS = 1 << INDEX_BITS;

  typedef enum logic [2:0] {
    B_INIT = 3'b001,
    B_IDLE = 3'b010,
    B_EVAL = 3'b100
  } back_state_t;

  ghts_pkg::slot_t mem [SLOTS];
  ghts_pkg::slot_t rd_data_r;
  ghts_pkg::slot_t wr_data;
  logic [INDEX_BITS-1:0] rd_addr, wr_addr;
  logic                  wr_en;

  back_state_t           state_r, state_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [31:0]           gen_now_r, gen_now_nxt;
  logic [INDEX_BITS-1:0] pos_r, pos_nxt;
  logic [INDEX_BITS-1:0] stop_r, stop_nxt;
  logic [INDEX_BITS-1:0] stale_pos_r, stale_pos_nxt;
  logic                  have_stale_r, have_stale_nxt;
  logic [31:0]           key_r, key_nxt;
  logic [31:0]           val_r, val_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ghts_pkg::out_item_t   out_data_r, out_data_nxt;

  logic                  out_free, hit, empty, at_stop, slot_old;
  logic [INDEX_BITS-1:0] start;

  assign init_busy = (state_r == B_INIT);
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free = !out_valid_r || out_ready;
  assign start    = pop_data.hash[INDEX_BITS-1:0];
  assign hit      = (rd_data_r.key == key_r);
  assign empty    = (rd_data_r.key == '0);
  assign at_stop  = (pos_r == stop_r);
  assign slot_old = (rd_data_r.gen != gen_now_r);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    gen_now_nxt    = gen_now_r;
    pos_nxt        = pos_r;
    stop_nxt       = stop_r;
    stale_pos_nxt  = stale_pos_r;
    have_stale_nxt = have_stale_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    rd_addr        = pos_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = '{key: key_r, value: val_r, gen: gen_now_r};
    unique case (state_r)
      B_INIT: begin
        // clearing pass over the whole table
        wr_en       = 1'b1;
        wr_addr     = clr_idx_r;
        wr_data     = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_data.op == ghts_pkg::OP_CLEAR) begin
            gen_now_nxt = gen_now_r + 32'd1;
          end else begin
            rd_addr        = start;
            pos_nxt        = start;
            stop_nxt       = start - 1'b1;
            have_stale_nxt = 1'b0;
            key_nxt        = pop_data.key;
            val_nxt        = pop_data.value;
            state_nxt      = B_EVAL;
          end
        end
      end
      B_EVAL: begin
        if (hit || empty || at_stop) begin
          if (out_free) begin
            wr_en         = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = B_IDLE;
            if (hit) begin
              out_data_nxt.is_different = (rd_data_r.value != val_r);
              out_data_nxt.is_stale     = slot_old;
            end else begin
              out_data_nxt.is_different = 1'b0;
              out_data_nxt.is_stale     = 1'b1;
              // full miss reuses the first stale slot passed
              if (!empty && have_stale_r) begin
                wr_addr = stale_pos_r;
              end
            end
          end
        end else begin
          if (!have_stale_r && slot_old) begin
            have_stale_nxt = 1'b1;
            stale_pos_nxt  = pos_r;
          end
          pos_nxt = pos_r + 1'b1;
          rd_addr = pos_r + 1'b1;
        end
      end
      default: state_nxt = B_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      clr_idx_r   <= '0;
      gen_now_r   <= ghts_pkg::GEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      gen_now_r   <= gen_now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    stop_r       <= stop_nxt;
    stale_pos_r  <= stale_pos_nxt;
    have_stale_r <= have_stale_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

>>> design/generational_hash_test_and_set.sv
// Generational hash table, test-and-set with linear probing.
// Input channel (in_valid/in_ready/in_data): op 0 tests and sets a key with
// expected_value, op 1 advances the generation and returns nothing.
// Result channel (out_valid/out_ready/out_data): one transaction per
// test-and-set, carrying is_different and is_stale, in input order.
// The front sequencer takes one test-and-set at a time: accept, six
// hash steps on one shared mix unit, then a push into a 4-entry queue;
// a clear skips the hash steps.
// The back engine pops from the queue and probes the table through its
// single read port, one slot per cycle. Long probe chains lower throughput.
// After reset a clearing pass writes all 2^INDEX_BITS slots, one per cycle,
// while in_ready stays low; the generation restarts at 3.
// A stalled receiver holds the result in the output register; the back
// engine stops at its next result, the queue fills, then in_ready drops.
module generational_hash_test_and_set #(
  parameter int INDEX_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ghts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ghts_pkg::out_item_t out_data
);

  logic            init_busy;
  logic            q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  ghts_pkg::work_t q_push_data, q_pop_data;

  ghts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold       (init_busy),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data)
  );

  ghts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data)
  );

  ghts_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_busy  (init_busy),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_data   (q_pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  a_init_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> init_busy)
    else $error("clearing pass not started after reset");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_no_pop_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop_valid && q_pop_ready) |-> !init_busy)
    else $error("queue popped during clearing pass");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("front took a second transaction while busy");

endmodule
